FILE: rtl/core/toq_pkg.sv
// ---------------------------------------------------------------------------
// Time-ordered event queue package
// Shared types and constants for the sorted event queue and its cells.
// ---------------------------------------------------------------------------
package toq_pkg;

   localparam int unsigned DEPTH   = 16;
   localparam int unsigned CNT_W   = $clog2(DEPTH + 1);
   localparam int unsigned TIME_W  = 32;
   localparam int unsigned KIND_W  = 4;
   localparam int unsigned DUR_W   = 16;
   localparam int unsigned COUNT_W = 5;

   typedef enum logic {
      CMD_INSERT = 1'b0,
      CMD_POP    = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef struct packed {
      logic [TIME_W-1:0] event_time;
      logic [KIND_W-1:0] event_kind;
      logic [DUR_W-1:0]  event_duration;
   } entry_type;

   typedef struct packed {
      cmd_type           cmd;
      logic [TIME_W-1:0] event_time;
      logic [KIND_W-1:0] event_kind;
      logic [DUR_W-1:0]  event_duration;
   } req_type;

   typedef struct packed {
      status_type         status;
      logic [TIME_W-1:0]  out_time;
      logic [KIND_W-1:0]  out_kind;
      logic [DUR_W-1:0]   out_duration;
      logic               now_empty;
      logic [COUNT_W-1:0] entry_count;
   } rsp_type;

   // Operation broadcast to every cell of the chain.
   typedef struct packed {
      logic      insert;
      logic      pop;
      entry_type item;
   } op_type;

endpackage

FILE: rtl/core/time_ordered_event_queue.sv
// ---------------------------------------------------------------------------
// Time-ordered event queue
// Bounded queue of events kept in ascending time order in a chain of cells.
// ---------------------------------------------------------------------------
// Each transaction is either an insert or a pop and gives one response. An
// insert lands behind every stored event of equal or earlier time, so ties
// leave in arrival order; a pop returns the earliest event. A full queue
// refuses inserts and an empty queue answers pops with an empty status.
// All cells compare their time with the new event in parallel and shift by
// one place, so a request can be taken in every cycle while the response
// register is free or being read.
// ---------------------------------------------------------------------------
module time_ordered_event_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  toq_pkg::req_type req_payload,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output toq_pkg::rsp_type rsp_payload
);
   import toq_pkg::*;

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   rsp_type          rsp_ff;
   rsp_type          rsp_in;

   op_type    op;
   entry_type cell_entry [DEPTH];
   logic      cell_keep  [DEPTH];
   logic      accept;
   logic      is_full;
   logic      is_empty;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign is_full   = (count_ff == CNT_W'(DEPTH));
   assign is_empty  = (count_ff == '0);

   always_comb begin
      op.item.event_time     = req_payload.event_time;
      op.item.event_kind     = req_payload.event_kind;
      op.item.event_duration = req_payload.event_duration;
      op.insert = accept && (req_payload.cmd == CMD_INSERT) && !is_full;
      op.pop    = accept && (req_payload.cmd == CMD_POP) && !is_empty;
   end

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic      occupied;
      logic      left_keep;
      entry_type left_entry;
      entry_type right_entry;

      assign occupied = (count_ff > CNT_W'(i));

      if (i == 0) begin : g_head
         assign left_keep  = 1'b1;
         assign left_entry = op.item;
      end else begin : g_body
         assign left_keep  = cell_keep[i-1];
         assign left_entry = cell_entry[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
         assign right_entry = cell_entry[i];
      end else begin : g_inner
         assign right_entry = cell_entry[i+1];
      end

      toq_cell u_cell (
         .clock       (clock),
         .op          (op),
         .occupied    (occupied),
         .left_keep   (left_keep),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .keep        (cell_keep[i]),
         .entry       (cell_entry[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (op.insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (op.pop) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_comb begin
      rsp_in              = rsp_ff;
      rsp_in.status       = STATUS_OK;
      rsp_in.out_time     = '0;
      rsp_in.out_kind     = '0;
      rsp_in.out_duration = '0;
      if (req_payload.cmd == CMD_INSERT) begin
         if (is_full) begin
            rsp_in.status = STATUS_FULL;
         end
      end else if (is_empty) begin
         rsp_in.status = STATUS_EMPTY;
      end else begin
         rsp_in.out_time     = cell_entry[0].event_time;
         rsp_in.out_kind     = cell_entry[0].event_kind;
         rsp_in.out_duration = cell_entry[0].event_duration;
      end
      rsp_in.now_empty   = (count_in == '0);
      rsp_in.entry_count = COUNT_W'(count_in);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

FILE: rtl/core/toq_cell.sv
// ---------------------------------------------------------------------------
// Event queue cell
// Holds one entry of the sorted chain and trades entries with its neighbours.
// ---------------------------------------------------------------------------
module toq_cell (
   input  logic               clock,
   input  toq_pkg::op_type    op,
   input  logic               occupied,
   input  logic               left_keep,
   input  toq_pkg::entry_type left_entry,
   input  toq_pkg::entry_type right_entry,
   output logic               keep,
   output toq_pkg::entry_type entry
);
   import toq_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   // An occupied cell whose time is not later than the new event stays put;
   // the first cell that does not keep takes the new event, the rest shift.
   assign keep = occupied && (entry_ff.event_time <= op.item.event_time);

   always_comb begin
      entry_in = entry_ff;
      if (op.insert) begin
         if (!keep) begin
            entry_in = left_keep ? op.item : left_entry;
         end
      end else if (op.pop) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule
